[rtl/p2a_pkg.sv]
`timescale 1ns / 1ps

package p2a_pkg;

  // Configuration register indexes.
  localparam logic REG_COLOR_MODE  = 1'b0;
  localparam logic REG_RAMP_SELECT = 1'b1;

  // Pixels darker than this luminance are shown in grey.
  localparam logic [7:0] DARK_LIMIT = 8'd24;
  localparam logic [3:0] DARK_INDEX = 4'd8;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_LEVELS  = 4;
  localparam int NUM_CHANNELS = 3;

  // Every palette component is one of four levels.
  localparam logic [0:NUM_LEVELS-1][7:0] LEVEL_VALUE = '{8'd0, 8'd128, 8'd192, 8'd255};

  // Palette entry as {red level, green level, blue level}.
  localparam logic [0:NUM_ENTRIES-1][5:0] PAL_LEVEL = '{
    6'b00_00_00, 6'b00_00_01, 6'b00_01_00, 6'b00_01_01,
    6'b01_00_00, 6'b01_00_01, 6'b01_01_00, 6'b10_10_10,
    6'b01_01_01, 6'b00_00_11, 6'b00_11_00, 6'b00_11_11,
    6'b11_00_00, 6'b11_00_11, 6'b11_11_00, 6'b11_11_11
  };

  localparam int CLASSIC_LEN = 69;
  localparam int DENSE_LEN   = 10;

  // Classic ramp, light to dark.
  localparam logic [6:0] CLASSIC_RAMP [CLASSIC_LEN] = '{
    7'd32, 7'd46, 7'd39, 7'd96, 7'd94, 7'd34, 7'd44, 7'd58, 7'd59, 7'd73,
    7'd108, 7'd33, 7'd105, 7'd126, 7'd43, 7'd95, 7'd45, 7'd63, 7'd93, 7'd91,
    7'd125, 7'd123, 7'd49, 7'd41, 7'd40, 7'd124, 7'd92, 7'd47, 7'd42, 7'd116,
    7'd102, 7'd106, 7'd114, 7'd120, 7'd110, 7'd117, 7'd118, 7'd99, 7'd122, 7'd88,
    7'd89, 7'd85, 7'd74, 7'd67, 7'd76, 7'd81, 7'd48, 7'd79, 7'd90, 7'd109,
    7'd119, 7'd113, 7'd112, 7'd100, 7'd98, 7'd107, 7'd104, 7'd97, 7'd111, 7'd42,
    7'd35, 7'd77, 7'd87, 7'd38, 7'd56, 7'd37, 7'd66, 7'd64, 7'd36
  };

  // Dense ramp, dark to light.
  localparam logic [6:0] DENSE_RAMP [DENSE_LEN] = '{
    7'd64, 7'd37, 7'd35, 7'd42, 7'd43, 7'd61, 7'd45, 7'd58, 7'd46, 7'd32
  };

  typedef logic [15:0] sq_t;
  typedef logic [17:0] dist_t;

  // Request moving down the cell chain.
  typedef struct packed {
    sq_t [0:NUM_CHANNELS-1][0:NUM_LEVELS-1] sq;
    logic [7:0] lum;
    dist_t      best_dist;
    logic [3:0] best_idx;
    logic       frame_end;
  } cell_data_t;

  // Quotient of p by 255, exact for p below 32640.
  function automatic logic [6:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[14:8];
  endfunction

endpackage

[rtl/p2a_pixel_if.sv]
`timescale 1ns / 1ps

interface p2a_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] grey_level;
  logic       frame_end;

  modport source(output valid, red, green, blue, grey_level, frame_end, input ready);
  modport sink(input valid, red, green, blue, grey_level, frame_end, output ready);
endinterface

[rtl/p2a_glyph_if.sv]
`timescale 1ns / 1ps

interface p2a_glyph_if;
  logic       valid;
  logic       ready;
  logic [6:0] glyph;
  logic [3:0] palette_index;
  logic       palette_valid;
  logic       frame_end_out;

  modport source(output valid, glyph, palette_index, palette_valid, frame_end_out,
                 input ready);
  modport sink(input valid, glyph, palette_index, palette_valid, frame_end_out,
               output ready);
endinterface

[rtl/p2a_cfg_if.sv]
`timescale 1ns / 1ps

interface p2a_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/p2a_front.sv]
`timescale 1ns / 1ps

module p2a_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 color_mode,
  p2a_pixel_if.sink            pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p2a_pkg::cell_data_t  out_data
);

  logic                [0:2][7:0] chan;
  p2a_pkg::cell_data_t            data_next;
  logic                [15:0]     lum_sum;

  assign chan = '{pixel.red, pixel.green, pixel.blue};

  // Stage takes a new request when empty or when its request moves on.
  assign pixel.ready = !out_valid || out_ready;

  // Luminance (the grey level in grey mode) and the squared distance of each channel to every palette level.
  always_comb begin
    logic [7:0] diff;
    lum_sum = 16'(pixel.red) * 16'd54 + 16'(pixel.green) * 16'd183
            + 16'(pixel.blue) * 16'd19;
    data_next = '0;
    for (int c = 0; c < p2a_pkg::NUM_CHANNELS; c++) begin
      for (int l = 0; l < p2a_pkg::NUM_LEVELS; l++) begin
        diff = (chan[c] >= p2a_pkg::LEVEL_VALUE[l]) ? chan[c] - p2a_pkg::LEVEL_VALUE[l]
                                                    : p2a_pkg::LEVEL_VALUE[l] - chan[c];
        data_next.sq[c][l] = 16'(diff) * 16'(diff);
      end
    end
    data_next.lum       = color_mode ? lum_sum[15:8] : pixel.grey_level;
    data_next.best_dist = '1;
    data_next.best_idx  = 4'd1;
    data_next.frame_end = pixel.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pixel.ready) begin
      out_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/p2a_cell.sv]
`timescale 1ns / 1ps

module p2a_cell #(
  parameter logic [3:0] INDEX = 4'd1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  p2a_pkg::cell_data_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p2a_pkg::cell_data_t  out_data
);

  localparam logic [5:0] LVL = p2a_pkg::PAL_LEVEL[INDEX];

  p2a_pkg::dist_t      entry_dist;
  p2a_pkg::cell_data_t data_next;

  assign in_ready = !out_valid || out_ready;

  // Distance to this cell's palette entry; a strictly smaller one takes over.
  always_comb begin
    entry_dist = 18'(in_data.sq[0][LVL[5:4]]) + 18'(in_data.sq[1][LVL[3:2]])
               + 18'(in_data.sq[2][LVL[1:0]]);
    data_next = in_data;
    if (entry_dist < in_data.best_dist) begin
      data_next.best_dist = entry_dist;
      data_next.best_idx  = INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/p2a_tail.sv]
`timescale 1ns / 1ps

module p2a_tail (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 color_mode,
  input  logic                 ramp_select,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  p2a_pkg::cell_data_t  in_data,
  p2a_glyph_if.source          result
);

  logic [6:0] classic_idx;
  logic [3:0] dense_idx;
  logic [6:0] glyph_next;
  logic [3:0] pidx_next;

  assign in_ready = !result.valid || result.ready;

  // Ramp positions: (255 - L) * 68 / 255 and L * 9 / 255.
  always_comb begin
    classic_idx = p2a_pkg::div255(16'(8'd255 - in_data.lum) * 16'd68);
    dense_idx   = 4'(p2a_pkg::div255(16'(in_data.lum) * 16'd9));
    glyph_next  = ramp_select ? p2a_pkg::DENSE_RAMP[dense_idx]
                              : p2a_pkg::CLASSIC_RAMP[classic_idx];
  end

  // Palette index: grey for dark pixels, the nearest entry otherwise, none in grey mode.
  always_comb begin
    if (!color_mode) begin
      pidx_next = 4'd0;
    end else if (in_data.lum < p2a_pkg::DARK_LIMIT) begin
      pidx_next = p2a_pkg::DARK_INDEX;
    end else begin
      pidx_next = in_data.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_ready) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result.glyph         <= glyph_next;
      result.palette_index <= pidx_next;
      result.palette_valid <= color_mode;
      result.frame_end_out <= in_data.frame_end;
    end
  end

endmodule

[rtl/pixel_to_ascii_glyph_color_core.sv]
`timescale 1ns / 1ps

// Turns one pixel per request into one ASCII glyph and, in color mode, a
// console palette index. A pixel passes a front stage (luminance and squared
// channel distances), a chain of fifteen palette cells (one per palette entry
// from 1 to 15, each keeping the nearest entry so far) and an output register.
// One pixel is taken every cycle unless the output stalls;
// each stage moves on as soon as the stage after it has room, so a stalled
// output fills the chain before the input stops. Ready passes back through
// all stages in the same cycle. Configuration is always accepted.
module pixel_to_ascii_glyph_color_core (
  input  logic        clk,
  input  logic        rst,
  p2a_cfg_if.sink     cfg,
  p2a_pixel_if.sink   pixel,
  p2a_glyph_if.source result
);

  localparam int NUM_CELLS = p2a_pkg::NUM_ENTRIES - 1;

  logic color_mode;
  logic ramp_select;

  logic                [0:NUM_CELLS] stage_valid;
  logic                [0:NUM_CELLS] stage_ready;
  p2a_pkg::cell_data_t               stage_data [0:NUM_CELLS];

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= 1'b1;
      ramp_select <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        p2a_pkg::REG_COLOR_MODE:  color_mode  <= cfg.data;
        p2a_pkg::REG_RAMP_SELECT: ramp_select <= cfg.data;
        default: ;
      endcase
    end
  end

  p2a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .color_mode (color_mode),
    .pixel      (pixel),
    .out_valid  (stage_valid[0]),
    .out_ready  (stage_ready[0]),
    .out_data   (stage_data[0])
  );

  // One cell per palette entry from 1 to 15.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    p2a_cell #(
      .INDEX (4'(i + 1))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  p2a_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .color_mode  (color_mode),
    .ramp_select (ramp_select),
    .in_valid    (stage_valid[NUM_CELLS]),
    .in_ready    (stage_ready[NUM_CELLS]),
    .in_data     (stage_data[NUM_CELLS]),
    .result      (result)
  );

endmodule

[verif/tb_pixel_to_ascii_glyph_color_core.sv]
`timescale 1ns / 1ps

module tb_pixel_to_ascii_glyph_color_core;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int PIPE_DEPTH   = 17;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_ITEMS  = 240;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_DIRECTED = 24;
  localparam int MAX_REPORTS  = 10;

  localparam int unsigned DARK_LUMA  = 24;
  localparam logic [3:0]  GREY_ENTRY = 4'd8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] grey_level;
    logic       frame_end;
  } pixel_req_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic [3:0] palette_index;
    logic       palette_valid;
    logic       frame_end;
  } glyph_res_t;

  // One directed request: the mode it runs in, the pixel, and optionally the
  // result written out by hand.
  typedef struct packed {
    bit       color_mode;
    bit       ramp_select;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] grey_level;
    bit       frame_end;
    bit       known;
    bit [6:0] glyph;
    bit [3:0] palette_index;
    bit       palette_valid;
  } dir_row_t;

  logic clk;
  logic rst;

  p2a_cfg_if   cfg_ch ();
  p2a_pixel_if pix_ch ();
  p2a_glyph_if glyph_ch ();

  pixel_to_ascii_glyph_color_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixel  (pix_ch),
    .result (glyph_ch)
  );

  // Console palette as 0xRRGGBB.
  bit [23:0] palette_rgb [16] = '{
    24'h000000, 24'h000080, 24'h008000, 24'h008080,
    24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
    24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  // Classic ramp, light to dark.
  bit [6:0] classic_glyphs [69] = '{
    7'd32, 7'd46, 7'd39, 7'd96, 7'd94, 7'd34, 7'd44, 7'd58, 7'd59, 7'd73,
    7'd108, 7'd33, 7'd105, 7'd126, 7'd43, 7'd95, 7'd45, 7'd63, 7'd93, 7'd91,
    7'd125, 7'd123, 7'd49, 7'd41, 7'd40, 7'd124, 7'd92, 7'd47, 7'd42, 7'd116,
    7'd102, 7'd106, 7'd114, 7'd120, 7'd110, 7'd117, 7'd118, 7'd99, 7'd122, 7'd88,
    7'd89, 7'd85, 7'd74, 7'd67, 7'd76, 7'd81, 7'd48, 7'd79, 7'd90, 7'd109,
    7'd119, 7'd113, 7'd112, 7'd100, 7'd98, 7'd107, 7'd104, 7'd97, 7'd111, 7'd42,
    7'd35, 7'd77, 7'd87, 7'd38, 7'd56, 7'd37, 7'd66, 7'd64, 7'd36
  };

  // Dense ramp, dark to light.
  bit [6:0] dense_glyphs [10] = '{
    7'd64, 7'd37, 7'd35, 7'd42, 7'd43, 7'd61, 7'd45, 7'd58, 7'd46, 7'd32
  };

  // Channel values on and between palette levels, where ties live.
  bit [7:0] probe_levels [8] = '{
    8'd0, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224, 8'd255
  };

  // Directed requests, grouped by mode.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // Color mode with the classic ramp, as after reset.
    '{1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1, 7'd32, 4'd15, 1'b1},
    '{1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 7'd36, 4'd8, 1'b1},
    '{1'b1, 1'b0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd160, 8'd160, 8'd160, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd23, 8'd23, 8'd23, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd24, 8'd24, 8'd24, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'd0, 8'd64, 8'd64, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    // Grey mode with the classic ramp.
    '{1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1, 7'd36, 4'd0, 1'b0},
    '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 7'd32, 4'd0, 1'b0},
    '{1'b0, 1'b0, 8'd12, 8'd200, 8'd77, 8'd128, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b0, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    // Grey mode with the dense ramp.
    '{1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 7'd64, 4'd0, 1'b0},
    '{1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1, 7'd32, 4'd0, 1'b0},
    '{1'b0, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h55, 1'b1, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd28, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    // Color mode with the dense ramp.
    '{1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1, 7'd32, 4'd15, 1'b1},
    '{1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 7'd64, 4'd8, 1'b1},
    '{1'b1, 1'b1, 8'd128, 8'd128, 8'd128, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    '{1'b1, 1'b1, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0},
    // Back to the reset mode.
    '{1'b1, 1'b0, 8'd192, 8'd192, 8'd192, 8'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0}
  };

  // Mode settings of the random phases; the last two are drawn at run time.
  bit [1:0] phase_modes [NUM_PHASES] = '{2'b10, 2'b01, 2'b11, 2'b00, 2'b10, 2'b10};

  glyph_res_t  expected_glyphs [$];
  int unsigned mismatches;

  // Mode as the block should currently hold it.
  bit shadow_color_mode;
  bit shadow_ramp_select;

  // Flags shared between the request and the response sides.
  bit hold_go;
  bit hold_done;
  bit quiet;
  bit sender_gappy;

  // Glyph and palette entry that a pixel should produce in the current mode.
  function automatic glyph_res_t predict_glyph(input pixel_req_t px);
    glyph_res_t  res;
    int unsigned luma;
    int unsigned best;
    int unsigned sq_dist;
    int unsigned slot;
    int          dr;
    int          dg;
    int          db;
    res = '0;
    res.frame_end = px.frame_end;
    if (shadow_color_mode) begin
      luma = (54 * px.red + 183 * px.green + 19 * px.blue) >> 8;
      res.palette_valid = 1'b1;
      if (luma < DARK_LUMA) begin
        res.palette_index = GREY_ENTRY;
      end else begin
        // Strict compare keeps the lower entry on a tie; black is never a candidate.
        best = 32'hFFFF_FFFF;
        for (int k = 1; k < 16; k++) begin
          dr = int'(px.red) - int'(palette_rgb[k][23:16]);
          dg = int'(px.green) - int'(palette_rgb[k][15:8]);
          db = int'(px.blue) - int'(palette_rgb[k][7:0]);
          sq_dist = dr * dr + dg * dg + db * db;
          if (sq_dist < best) begin
            best = sq_dist;
            res.palette_index = 4'(k);
          end
        end
      end
    end else begin
      luma = px.grey_level;
    end
    if (shadow_ramp_select) begin
      slot = luma * 9 / 255;
      res.glyph = dense_glyphs[slot];
    end else begin
      slot = (255 - luma) * 68 / 255;
      res.glyph = classic_glyphs[slot];
    end
    return res;
  endfunction

  // Channel value near a palette level or a midpoint between two levels.
  function automatic logic [7:0] near_level();
    int v;
    v = int'(probe_levels[$urandom_range(7)]) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Random pixel, biased toward ties, the dark limit and channel extremes.
  function automatic pixel_req_t random_pixel();
    pixel_req_t px;
    logic [7:0] v;
    px.red        = 8'($urandom);
    px.green      = 8'($urandom);
    px.blue       = 8'($urandom);
    px.grey_level = 8'($urandom);
    px.frame_end  = ($urandom_range(7) == 0);
    case ($urandom_range(5))
      0: begin
        px.red   = near_level();
        px.green = near_level();
        px.blue  = near_level();
      end
      1: begin
        v = ($urandom_range(1) == 0) ? 8'($urandom_range(40)) : 8'($urandom);
        px.red   = v;
        px.green = v;
        px.blue  = v;
      end
      2: begin
        px.red   = 8'($urandom_range(60));
        px.green = 8'($urandom_range(30));
        px.blue  = 8'($urandom_range(255));
      end
      3: begin
        px.red   = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
        px.green = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
        px.blue  = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  // Offer one pixel and record its expected result once it is taken.
  task automatic send_pixel(input pixel_req_t px, input bit known, input glyph_res_t given);
    int unsigned gap;
    if (!quiet && sender_gappy && $urandom_range(3) == 0) begin
      pix_ch.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.red        <= px.red;
    pix_ch.green      <= px.green;
    pix_ch.blue       <= px.blue;
    pix_ch.grey_level <= px.grey_level;
    pix_ch.frame_end  <= px.frame_end;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    expected_glyphs.push_back(known ? given : predict_glyph(px));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_glyphs.size() != 0);
  endtask

  // Stop pixels, let the pipeline empty, then write both mode registers.
  task automatic set_mode(input bit color_mode, input bit ramp_select);
    pix_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= p2a_pkg::REG_COLOR_MODE;
    cfg_ch.data  <= color_mode;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    shadow_color_mode = color_mode;
    cfg_ch.index <= p2a_pkg::REG_RAMP_SELECT;
    cfg_ch.data  <= ramp_select;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    shadow_ramp_select = ramp_select;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 300_000);
    $display("simulation failed");
    $finish;
  end

  // Response side: random stalls, one long hold-off, none at the end.
  initial begin
    int unsigned burst;
    int unsigned tick;
    bit          choppy;
    glyph_ch.ready = 1'b0;
    choppy = 1'b1;
    tick = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_go && !hold_done) begin
        glyph_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        glyph_ch.ready <= 1'b1;
        hold_done = 1'b1;
      end else if (!quiet && choppy && $urandom_range(3) == 0) begin
        glyph_ch.ready <= 1'b0;
        burst = $urandom_range(1, 11);
        repeat (burst) @(posedge clk);
        glyph_ch.ready <= 1'b1;
      end else begin
        glyph_ch.ready <= 1'b1;
      end
      tick++;
      if (tick % 128 == 0) choppy = $urandom_range(1);
      @(posedge clk);
    end
  end

  // Compare each result taken with the oldest one outstanding.
  always @(posedge clk) begin
    glyph_res_t want;
    if (!rst && glyph_ch.valid === 1'b1 && glyph_ch.ready === 1'b1) begin
      if (expected_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: glyph %0d index %0d valid %0b end %0b",
                   $time, glyph_ch.glyph, glyph_ch.palette_index, glyph_ch.palette_valid,
                   glyph_ch.frame_end_out);
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_ch.glyph !== want.glyph || glyph_ch.palette_index !== want.palette_index ||
            glyph_ch.palette_valid !== want.palette_valid ||
            glyph_ch.frame_end_out !== want.frame_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected glyph %0d index %0d valid %0b end %0b, got %0d %0d %0b %0b",
                     $time, want.glyph, want.palette_index, want.palette_valid, want.frame_end,
                     glyph_ch.glyph, glyph_ch.palette_index, glyph_ch.palette_valid,
                     glyph_ch.frame_end_out);
        end
      end
    end
  end

  // Request side: reset, directed table, random phases, drain.
  initial begin
    pixel_req_t px;
    glyph_res_t given;
    dir_row_t   row;
    rst = 1'b1;
    pix_ch.valid      = 1'b0;
    pix_ch.red        = '0;
    pix_ch.green      = '0;
    pix_ch.blue       = '0;
    pix_ch.grey_level = '0;
    pix_ch.frame_end  = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = p2a_pkg::REG_COLOR_MODE;
    cfg_ch.data  = 1'b0;
    mismatches = 0;
    shadow_color_mode  = 1'b1;
    shadow_ramp_select = 1'b0;
    hold_go      = 1'b0;
    hold_done    = 1'b0;
    quiet        = 1'b0;
    sender_gappy = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the mode is rewritten whenever a row asks for another one.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.color_mode != shadow_color_mode || row.ramp_select != shadow_ramp_select)
        set_mode(row.color_mode, row.ramp_select);
      px = '{row.red, row.green, row.blue, row.grey_level, row.frame_end};
      given = '{row.glyph, row.palette_index, row.palette_valid, row.frame_end};
      send_pixel(px, row.known, given);
    end

    // Random phases, each with its mode written first.
    phase_modes[4] = 2'($urandom);
    phase_modes[5] = 2'($urandom);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_modes[p][1], phase_modes[p][0]);
      if (p == 1) hold_go = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) sender_gappy = $urandom_range(1);
        // Once, let every outstanding result come back before going on.
        if (p == 2 && i == PHASE_ITEMS / 2) begin
          pix_ch.valid <= 1'b0;
          wait_drained();
        end
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    pix_ch.valid <= 1'b0;
    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0 && expected_glyphs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
